// ----- hdl/triangle_support_point_core_defines.svh -----
// assertion macros used by the port-level checker file
`ifndef TRIANGLE_SUPPORT_POINT_CORE_DEFINES_SVH
`define TRIANGLE_SUPPORT_POINT_CORE_DEFINES_SVH

// all macros sample on clk and expect clk in scope; the two reset-gated ones also expect rst_n

// same-cycle implication, off while reset is low
`define TSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is low
`define TSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define TSP_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/tsp_pkg.sv -----
// shared types and constants for the triangle support point core
package tsp_pkg;

  localparam int COORD_BITS = 16;
  localparam int QUAT_BITS  = 16;
  localparam int VTX_BITS   = 48;
  localparam int NUM_VTX    = 3;

  // quaternion products and matrix entries
  localparam int QPROD_W = 2 * QUAT_BITS;
  localparam int QSUM_W  = QPROD_W + 4;
  localparam int MAT_W   = QSUM_W - 12;

  // rotation, world coordinate and dot product widths
  localparam int PROD_W  = MAT_W + COORD_BITS;
  localparam int ACC_W   = PROD_W + 2;
  localparam int ROT_W   = ACC_W - 16;
  localparam int WORLD_W = ROT_W + 1;
  localparam int DP_W    = 2 * COORD_BITS;
  localparam int DOT_W   = DP_W + 2;

  localparam logic signed [WORLD_W-1:0] SAT_HI = WORLD_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [WORLD_W-1:0] SAT_LO = -SAT_HI - WORLD_W'(1);

  // configuration register indexes
  localparam logic [1:0] REG_VERTEX_A = 2'd0;
  localparam logic [1:0] REG_VERTEX_B = 2'd1;
  localparam logic [1:0] REG_VERTEX_C = 2'd2;

  // vertex codes on the result word
  localparam logic [1:0] IDX_A = 2'd0;
  localparam logic [1:0] IDX_B = 2'd1;
  localparam logic [1:0] IDX_C = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] dir_x;
    logic signed [COORD_BITS-1:0] dir_y;
    logic signed [COORD_BITS-1:0] dir_z;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic signed [QUAT_BITS-1:0]  quat_w;
    logic signed [QUAT_BITS-1:0]  quat_x;
    logic signed [QUAT_BITS-1:0]  quat_y;
    logic signed [QUAT_BITS-1:0]  quat_z;
  } tsp_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] support_x;
    logic signed [COORD_BITS-1:0] support_y;
    logic signed [COORD_BITS-1:0] support_z;
    logic [1:0]                   chosen_index;
  } tsp_out_t;

  // stage load enables for the matrix builder
  typedef struct packed {
    logic s1;
    logic s2;
  } tsp_adv_t;

  typedef logic [2:0][2:0][MAT_W-1:0] tsp_mat_t;

endpackage

// ----- hdl/tsp_quat_matrix.sv -----
// two-stage rotation matrix builder from a Q1.14 quaternion
module tsp_quat_matrix (
  input  logic                                 clk,
  input  tsp_pkg::tsp_adv_t                    adv,
  input  logic signed [tsp_pkg::QUAT_BITS-1:0] quat_w,
  input  logic signed [tsp_pkg::QUAT_BITS-1:0] quat_x,
  input  logic signed [tsp_pkg::QUAT_BITS-1:0] quat_y,
  input  logic signed [tsp_pkg::QUAT_BITS-1:0] quat_z,
  output tsp_pkg::tsp_mat_t                    mat
);
  import tsp_pkg::*;

  localparam logic signed [QSUM_W-1:0] ONE_Q28 = QSUM_W'(64'sd1 <<< 28);
  localparam logic signed [QSUM_W-1:0] HALF_LSB = QSUM_W'(64'sd1 <<< 11);

  logic signed [QPROD_W-1:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic signed [QSUM_W-1:0]  e_nxt [3][3];
  tsp_mat_t                  mat_r;
  tsp_mat_t                  mat_nxt;

  function automatic logic signed [QSUM_W-1:0] ext(input logic signed [QPROD_W-1:0] v);
    return QSUM_W'(v);
  endfunction

  // round Q.28 to Q.16, half up
  function automatic logic [MAT_W-1:0] rnd(input logic signed [QSUM_W-1:0] v);
    logic signed [QSUM_W-1:0] t;
    t = v + HALF_LSB;
    return t[QSUM_W-1:12];
  endfunction

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      xx_r <= QPROD_W'(quat_x) * QPROD_W'(quat_x);
      yy_r <= QPROD_W'(quat_y) * QPROD_W'(quat_y);
      zz_r <= QPROD_W'(quat_z) * QPROD_W'(quat_z);
      xy_r <= QPROD_W'(quat_x) * QPROD_W'(quat_y);
      xz_r <= QPROD_W'(quat_x) * QPROD_W'(quat_z);
      yz_r <= QPROD_W'(quat_y) * QPROD_W'(quat_z);
      wx_r <= QPROD_W'(quat_w) * QPROD_W'(quat_x);
      wy_r <= QPROD_W'(quat_w) * QPROD_W'(quat_y);
      wz_r <= QPROD_W'(quat_w) * QPROD_W'(quat_z);
    end
  end

  always_comb begin
    e_nxt[0][0] = ONE_Q28 - ((ext(yy_r) + ext(zz_r)) <<< 1);
    e_nxt[0][1] = (ext(xy_r) - ext(wz_r)) <<< 1;
    e_nxt[0][2] = (ext(xz_r) + ext(wy_r)) <<< 1;
    e_nxt[1][0] = (ext(xy_r) + ext(wz_r)) <<< 1;
    e_nxt[1][1] = ONE_Q28 - ((ext(xx_r) + ext(zz_r)) <<< 1);
    e_nxt[1][2] = (ext(yz_r) - ext(wx_r)) <<< 1;
    e_nxt[2][0] = (ext(xz_r) - ext(wy_r)) <<< 1;
    e_nxt[2][1] = (ext(yz_r) + ext(wx_r)) <<< 1;
    e_nxt[2][2] = ONE_Q28 - ((ext(xx_r) + ext(yy_r)) <<< 1);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mat_nxt[r][c] = rnd(e_nxt[r][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      mat_r <= mat_nxt;
    end
  end

  assign mat = mat_r;

endmodule

// ----- hdl/triangle_support_point_core.sv -----
// top level of the triangle support point core
// GJK support mapping for a posed triangle. Each input word carries a search
// direction, a position and a Q1.14 quaternion; the result word is the world
// vertex (rotated by the quaternion's matrix, translated, saturated to Q8.8)
// with the largest dot against the direction, the earliest vertex on ties.
// One word is taken every cycle while in_stall is low; each word passes
// through the six register stages in order: quaternion products, matrix
// entries, matrix-by-vertex products, world coordinates, direction products,
// and the dot compare that feeds the output register. Stalls hold each stage
// only while the stage ahead is full, so bubbles close up under a stall.
// The user writes vertices through the cfg port only while no word is in flight; the core does not enforce this.
module triangle_support_point_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tsp_pkg::tsp_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tsp_pkg::tsp_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [tsp_pkg::VTX_BITS-1:0]      cfg_data
);
  import tsp_pkg::*;

  localparam int NSTG = 6;
  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'sd1 <<< 15);

  logic [VTX_BITS-1:0] vtx_r [NUM_VTX];

  logic [NSTG:1] vld_r, vld_nxt, rdy;

  // carried operands
  logic signed [COORD_BITS-1:0] pos1_r [3], pos2_r [3], pos3_r [3];
  logic signed [COORD_BITS-1:0] dir1_r [3], dir2_r [3], dir3_r [3], dir4_r [3];

  tsp_adv_t adv;
  tsp_mat_t mat;

  logic signed [PROD_W-1:0]     prod_r   [NUM_VTX][3][3];
  logic signed [PROD_W-1:0]     prod_nxt [NUM_VTX][3][3];
  logic signed [COORD_BITS-1:0] wv4_r    [NUM_VTX][3];
  logic signed [COORD_BITS-1:0] wv4_nxt  [NUM_VTX][3];
  logic signed [COORD_BITS-1:0] wv5_r    [NUM_VTX][3];
  logic signed [DP_W-1:0]       dp_r     [NUM_VTX][3];
  logic signed [DP_W-1:0]       dp_nxt   [NUM_VTX][3];
  logic signed [DOT_W-1:0]      dot_nxt  [NUM_VTX];
  logic [1:0]                   best_nxt;
  tsp_out_t                     out_r, out_nxt;

  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [WORLD_W-1:0] v);
    logic signed [COORD_BITS-1:0] res;
    priority if (v > SAT_HI) begin
      res = SAT_HI[COORD_BITS-1:0];
    end else if (v < SAT_LO) begin
      res = SAT_LO[COORD_BITS-1:0];
    end else begin
      res = v[COORD_BITS-1:0];
    end
    return res;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VTX; i++) begin
        vtx_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VERTEX_A: vtx_r[0] <= cfg_data;
        REG_VERTEX_B: vtx_r[1] <= cfg_data;
        REG_VERTEX_C: vtx_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or the stage ahead moves
  always_comb begin
    rdy[NSTG] = !vld_r[NSTG] || !out_stall;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt = vld_r;
    if (rdy[1]) begin
      vld_nxt[1] = in_valid;
    end
    for (int k = 2; k <= NSTG; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall = !rdy[1];
  assign adv      = '{s1: rdy[1], s2: rdy[2]};

  tsp_quat_matrix u_mat (
    .clk    (clk),
    .adv    (adv),
    .quat_w (in_data.quat_w),
    .quat_x (in_data.quat_x),
    .quat_y (in_data.quat_y),
    .quat_z (in_data.quat_z),
    .mat    (mat)
  );

  // stages 1 and 2: carry position and direction beside the matrix builder
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pos1_r[0] <= in_data.pos_x;
      pos1_r[1] <= in_data.pos_y;
      pos1_r[2] <= in_data.pos_z;
      dir1_r[0] <= in_data.dir_x;
      dir1_r[1] <= in_data.dir_y;
      dir1_r[2] <= in_data.dir_z;
    end
    if (rdy[2]) begin
      pos2_r <= pos1_r;
      dir2_r <= dir1_r;
    end
  end

  // stage 3: matrix entry times vertex coordinate
  always_comb begin
    for (int v = 0; v < NUM_VTX; v++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_nxt[v][r][c] = PROD_W'(signed'(mat[r][c])) *
                              PROD_W'(signed'(vtx_r[v][c*COORD_BITS +: COORD_BITS]));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      prod_r <= prod_nxt;
      pos3_r <= pos2_r;
      dir3_r <= dir2_r;
    end
  end

  // stage 4: row sums, round to Q8.8, translate, saturate
  always_comb begin
    logic signed [ACC_W-1:0]   acc;
    logic signed [WORLD_W-1:0] wld;
    for (int v = 0; v < NUM_VTX; v++) begin
      for (int r = 0; r < 3; r++) begin
        acc = ACC_W'(prod_r[v][r][0]) + ACC_W'(prod_r[v][r][1]) +
              ACC_W'(prod_r[v][r][2]) + HALF_LSB;
        wld = WORLD_W'(signed'(acc[ACC_W-1:16])) + WORLD_W'(pos3_r[r]);
        wv4_nxt[v][r] = sat(wld);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      wv4_r  <= wv4_nxt;
      dir4_r <= dir3_r;
    end
  end

  // stage 5: per-axis direction products
  always_comb begin
    for (int v = 0; v < NUM_VTX; v++) begin
      for (int c = 0; c < 3; c++) begin
        dp_nxt[v][c] = DP_W'(wv4_r[v][c]) * DP_W'(dir4_r[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      dp_r  <= dp_nxt;
      wv5_r <= wv4_r;
    end
  end

  // stage 6: dot sums and pick, earliest vertex wins a tie
  always_comb begin
    logic signed [DOT_W-1:0] best_dot;
    for (int v = 0; v < NUM_VTX; v++) begin
      dot_nxt[v] = DOT_W'(dp_r[v][0]) + DOT_W'(dp_r[v][1]) + DOT_W'(dp_r[v][2]);
    end
    best_nxt = IDX_A;
    best_dot = dot_nxt[0];
    if (dot_nxt[1] > best_dot) begin
      best_nxt = IDX_B;
      best_dot = dot_nxt[1];
    end
    if (dot_nxt[2] > best_dot) begin
      best_nxt = IDX_C;
    end
    unique case (best_nxt)
      IDX_B: begin
        out_nxt.support_x = wv5_r[1][0];
        out_nxt.support_y = wv5_r[1][1];
        out_nxt.support_z = wv5_r[1][2];
      end
      IDX_C: begin
        out_nxt.support_x = wv5_r[2][0];
        out_nxt.support_y = wv5_r[2][1];
        out_nxt.support_z = wv5_r[2][2];
      end
      default: begin
        out_nxt.support_x = wv5_r[0][0];
        out_nxt.support_y = wv5_r[0][1];
        out_nxt.support_z = wv5_r[0][2];
      end
    endcase
    out_nxt.chosen_index = best_nxt;
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[NSTG];
  assign out_data  = out_r;

endmodule

// ----- hdl/tsp_checker.sv -----
// port-level checker for the triangle support point core, with its bind
`include "triangle_support_point_core_defines.svh"

module tsp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input tsp_pkg::tsp_out_t            out_data
);
  import tsp_pkg::*;

  logic idx_ok;
  logic out_free;
  logic out_held;

  assign idx_ok   = (out_data.chosen_index == IDX_A) || (out_data.chosen_index == IDX_B) ||
                    (out_data.chosen_index == IDX_C);
  assign out_free = !out_valid || !out_stall;
  assign out_held = out_valid && out_stall;

  // a waiting result word holds
  `TSP_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_data), "stalled word changed")

  // winner code of a valid result word is always a real vertex
  `TSP_ASSERT_NOW(a_idx_range, out_valid, idx_ok, "chosen index out of range")

  // nothing comes out right after reset
  `TSP_ASSERT_ALWAYS_NEXT(a_reset_empty, !rst_n, !out_valid, "result word valid after reset")

  // input side only waits when the output side is blocked
  `TSP_ASSERT_NOW(a_no_false_stall, out_free, !in_stall, "input stalled with free output")

endmodule

bind triangle_support_point_core tsp_checker u_tsp_checker (.*);

// ----- verif/triangle_support_point_core_checker.sv -----
// checker for the triangle support point core: shadows the vertices, predicts and compares
module triangle_support_point_core_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  tsp_pkg::tsp_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  tsp_pkg::tsp_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [tsp_pkg::VTX_BITS-1:0]  cfg_data,
  output int                            mismatch_count,
  output int                            words_in_flight,
  output int                            results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import tsp_pkg::*;

  logic [NUM_VTX-1:0][VTX_BITS-1:0] vertex_shadow;
  tsp_out_t support_q[$];

  function automatic longint clamp_coord(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // world vertex with the largest dot against the direction, earliest on ties
  function automatic tsp_out_t predict_support(tsp_in_t q,
                                               logic [NUM_VTX-1:0][VTX_BITS-1:0] vtx);
    longint qw, qx, qy, qz;
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
    longint m[9];
    longint dvec[3];
    longint pvec[3];
    longint v[3];
    longint wv[3];
    longint best[3];
    longint acc;
    longint dot;
    longint best_dot;
    int best_i;
    tsp_out_t r;
    qw = longint'($signed(q.quat_w));
    qx = longint'($signed(q.quat_x));
    qy = longint'($signed(q.quat_y));
    qz = longint'($signed(q.quat_z));
    dvec[0] = longint'($signed(q.dir_x));
    dvec[1] = longint'($signed(q.dir_y));
    dvec[2] = longint'($signed(q.dir_z));
    pvec[0] = longint'($signed(q.pos_x));
    pvec[1] = longint'($signed(q.pos_y));
    pvec[2] = longint'($signed(q.pos_z));
    xx = qx * qx; yy = qy * qy; zz = qz * qz;
    xy = qx * qy; xz = qx * qz; yz = qy * qz;
    wx = qw * qx; wy = qw * qy; wz = qw * qz;
    // entries exact in q.28
    m[0] = (longint'(1) <<< 28) - 2 * (yy + zz);
    m[1] = 2 * (xy - wz);
    m[2] = 2 * (xz + wy);
    m[3] = 2 * (xy + wz);
    m[4] = (longint'(1) <<< 28) - 2 * (xx + zz);
    m[5] = 2 * (yz - wx);
    m[6] = 2 * (xz - wy);
    m[7] = 2 * (yz + wx);
    m[8] = (longint'(1) <<< 28) - 2 * (xx + yy);
    // round half up to q.16
    for (int k = 0; k < 9; k++) m[k] = (m[k] + 2048) >>> 12;
    best_dot = 0;
    best_i = 0;
    best[0] = 0; best[1] = 0; best[2] = 0;
    for (int i = 0; i < NUM_VTX; i++) begin
      for (int c = 0; c < 3; c++)
        v[c] = longint'($signed(vtx[i][c*COORD_BITS +: COORD_BITS]));
      for (int rr = 0; rr < 3; rr++) begin
        acc = m[3*rr] * v[0] + m[3*rr+1] * v[1] + m[3*rr+2] * v[2];
        acc = (acc + 32768) >>> 16;
        wv[rr] = clamp_coord(acc + pvec[rr]);
      end
      dot = wv[0] * dvec[0] + wv[1] * dvec[1] + wv[2] * dvec[2];
      if (i == 0 || dot > best_dot) begin
        best_dot = dot;
        best_i = i;
        best[0] = wv[0]; best[1] = wv[1]; best[2] = wv[2];
      end
    end
    r.support_x = COORD_BITS'(best[0]);
    r.support_y = COORD_BITS'(best[1]);
    r.support_z = COORD_BITS'(best[2]);
    r.chosen_index = (best_i == 0) ? IDX_A : (best_i == 1) ? IDX_B : IDX_C;
    return r;
  endfunction

  function automatic int field_differs(string field, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : monitor
    tsp_out_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      vertex_shadow <= '0;
      support_q.delete();
      mismatch_count <= 0;
      words_in_flight <= 0;
      results_seen <= 0;
    end else begin
      // compare before queueing, so a stray word never meets its own prediction
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (support_q.size() == 0) begin
          $error("result word with nothing expected: x %0d y %0d z %0d index %0d",
                 out_data.support_x, out_data.support_y, out_data.support_z,
                 out_data.chosen_index);
          errs++;
        end else begin
          want = support_q.pop_front();
          errs += field_differs("support_x", longint'(want.support_x),
                                longint'(out_data.support_x));
          errs += field_differs("support_y", longint'(want.support_y),
                                longint'(out_data.support_y));
          errs += field_differs("support_z", longint'(want.support_z),
                                longint'(out_data.support_z));
          errs += field_differs("chosen_index", longint'(want.chosen_index),
                                longint'(out_data.chosen_index));
        end
      end
      if (in_valid && !in_stall) support_q = {support_q, predict_support(in_data, vertex_shadow)};
      if (cfg_we) begin
        case (cfg_index)
          REG_VERTEX_A: vertex_shadow[0] <= cfg_data;
          REG_VERTEX_B: vertex_shadow[1] <= cfg_data;
          REG_VERTEX_C: vertex_shadow[2] <= cfg_data;
          default: ;
        endcase
      end
      mismatch_count <= mismatch_count + errs;
      words_in_flight <= support_q.size();
    end
  end

endmodule

// ----- verif/triangle_support_point_core_tb.sv -----
// testbench top for the triangle support point core: stimulus, stall pattern and verdict
module triangle_support_point_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tsp_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_QUERIES = 100;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCKS} stall_mode_e;
  typedef enum logic [1:0] {TRI_WIDE, TRI_SMALL, TRI_TIED, TRI_EXTREME} tri_kind_e;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  tsp_in_t             in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tsp_out_t            out_data;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = REG_VERTEX_A;
  logic [VTX_BITS-1:0] cfg_data = '0;

  int mismatch_count;
  int words_in_flight;
  int results_seen;
  int queries_sent = 0;
  int triangles_loaded = 0;
  int burst_left = 0;

  stall_mode_e stall_mode = STALL_NONE;
  int stall_left = 0;

  triangle_support_point_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  triangle_support_point_core_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .words_in_flight (words_in_flight),
    .results_seen    (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d words still in flight", words_in_flight);
    $display("triangle_support_point_core_tb: errors");
    $finish;
  end

  // receiver stall pattern: a new random mode is picked whenever the countdown runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left % 16) >= 10;
    endcase
  end

  function automatic logic [VTX_BITS-1:0] pack_vertex(int x, int y, int z);
    return {COORD_BITS'(z), COORD_BITS'(y), COORD_BITS'(x)};
  endfunction

  function automatic tsp_in_t make_query(int dx, int dy, int dz, int px, int py, int pz,
                                         int qw, int qx, int qy, int qz);
    tsp_in_t q;
    q.dir_x = COORD_BITS'(dx); q.dir_y = COORD_BITS'(dy); q.dir_z = COORD_BITS'(dz);
    q.pos_x = COORD_BITS'(px); q.pos_y = COORD_BITS'(py); q.pos_z = COORD_BITS'(pz);
    q.quat_w = QUAT_BITS'(qw); q.quat_x = QUAT_BITS'(qx);
    q.quat_y = QUAT_BITS'(qy); q.quat_z = QUAT_BITS'(qz);
    return q;
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic int unit_part();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  function automatic tsp_in_t rand_query();
    tsp_in_t q;
    q = tsp_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    // mostly modest positions so the rotation shows through the clamp
    if ($urandom_range(0, 9) < 7) begin
      q.pos_x = COORD_BITS'(small_coord());
      q.pos_y = COORD_BITS'(small_coord());
      q.pos_z = COORD_BITS'(small_coord());
    end
    if ($urandom_range(0, 7) == 0) q.dir_x = '0;
    if ($urandom_range(0, 7) == 0) q.dir_y = '0;
    if ($urandom_range(0, 7) == 0) q.dir_z = '0;
    case ($urandom_range(0, 4))
      0: begin
        q.quat_w = 16'sd16384; q.quat_x = '0; q.quat_y = '0; q.quat_z = '0;
      end
      1, 2: begin
        q.quat_w = QUAT_BITS'(unit_part()); q.quat_x = QUAT_BITS'(unit_part());
        q.quat_y = QUAT_BITS'(unit_part()); q.quat_z = QUAT_BITS'(unit_part());
      end
      3: begin
        q.quat_w = QUAT_BITS'(unit_part()); q.quat_x = '0; q.quat_y = '0; q.quat_z = '0;
        case ($urandom_range(0, 2))
          0: q.quat_x = QUAT_BITS'(unit_part());
          1: q.quat_y = QUAT_BITS'(unit_part());
          default: q.quat_z = QUAT_BITS'(unit_part());
        endcase
      end
      default: ;
    endcase
    return q;
  endfunction

  // sender bursts with random gaps; payload holds while stalled
  task automatic send_query(input tsp_in_t q);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_data <= q;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    queries_sent++;
  endtask

  // stop sending and wait for every result to be checked
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic load_triangle(input logic [VTX_BITS-1:0] a, input logic [VTX_BITS-1:0] b,
                               input logic [VTX_BITS-1:0] c);
    cfg_we <= 1'b1;
    cfg_index <= REG_VERTEX_A;
    cfg_data <= a;
    @(posedge clk);
    cfg_index <= REG_VERTEX_B;
    cfg_data <= b;
    @(posedge clk);
    cfg_index <= REG_VERTEX_C;
    cfg_data <= c;
    @(posedge clk);
    // unused index must leave the vertices alone
    cfg_index <= REG_UNUSED;
    cfg_data <= VTX_BITS'({$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    triangles_loaded++;
  endtask

  task automatic load_random_triangle(input tri_kind_e kind);
    logic [VTX_BITS-1:0] vtx[3];
    int e[9];
    for (int i = 0; i < 3; i++) begin
      case (kind)
        TRI_WIDE: vtx[i] = VTX_BITS'({$urandom, $urandom});
        TRI_EXTREME: begin
          for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 3))
              0: e[3*i+k] = 32767;
              1: e[3*i+k] = -32768;
              2: e[3*i+k] = -1;
              default: e[3*i+k] = 0;
            endcase
          end
          vtx[i] = pack_vertex(e[3*i], e[3*i+1], e[3*i+2]);
        end
        default: vtx[i] = pack_vertex(small_coord(), small_coord(), small_coord());
      endcase
    end
    // shared vertices force dot ties
    if (kind == TRI_TIED) begin
      vtx[1] = vtx[0];
      if ($urandom_range(0, 1) == 0) vtx[2] = vtx[0];
    end
    load_triangle(vtx[0], vtx[1], vtx[2]);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // vertices still at their reset value: every vertex ties
    send_query(rand_query());
    send_query(make_query(-32768, 32767, 1, 32767, -32768, 0, 16384, 0, 0, 0));
    settle();

    load_triangle(pack_vertex(256, 0, 0), pack_vertex(0, 256, 0), pack_vertex(0, 0, 256));
    burst_left = 20;
    send_query(make_query(256, 0, 0, 0, 0, 0, 16384, 0, 0, 0));
    send_query(make_query(0, 256, 0, 0, 0, 0, 16384, 0, 0, 0));
    send_query(make_query(0, 0, 256, 0, 0, 0, 16384, 0, 0, 0));
    // zero and equal-dot directions keep the first vertex
    send_query(make_query(0, 0, 0, 100, -100, 50, 16384, 0, 0, 0));
    send_query(make_query(-256, -256, -256, 0, 0, 0, 16384, 0, 0, 0));
    // half turns about each axis and a negated identity quaternion
    send_query(make_query(256, 0, 0, 0, 0, 0, 0, 0, 0, 16384));
    send_query(make_query(0, 256, 0, 0, 0, 0, 0, 16384, 0, 0));
    send_query(make_query(0, 0, 256, 0, 0, 0, 0, 0, 16384, 0));
    send_query(make_query(256, 256, 0, 0, 0, 0, -16384, 0, 0, 0));
    // non-unit, out-of-range and zero quaternions
    send_query(make_query(256, -256, 256, 0, 0, 0, 16384, 16384, 16384, 16384));
    send_query(make_query(-256, 256, 256, 0, 0, 0, -32768, -32768, -32768, -32768));
    send_query(make_query(1, 2, 3, 0, 0, 0, 0, 0, 0, 0));
    // clamp at both ends, then quarter turns with full-scale directions
    send_query(make_query(256, 0, 0, 32767, 32767, 32767, 16384, 0, 0, 0));
    send_query(make_query(-256, 0, 0, -32768, -32768, -32768, 16384, 0, 0, 0));
    send_query(make_query(32767, 32767, 32767, 0, 0, 0, 11585, 0, 11585, 0));
    send_query(make_query(-32768, -32768, -32768, 0, 0, 0, 11585, 11585, 0, 0));
    settle();

    load_triangle(pack_vertex(32767, 32767, 32767), pack_vertex(-32768, -32768, -32768),
                  {VTX_BITS{1'b1}});
    send_query(make_query(1, 1, 1, 32767, 32767, 32767, 16384, 0, 0, 0));
    send_query(make_query(-1, -1, -1, -32768, -32768, -32768, 16384, 0, 0, 0));
    send_query(make_query(32767, -32768, 32767, 0, 0, 0, 16384, 16384, 16384, 16384));
    send_query(make_query(-32768, 32767, -32768, 0, 0, 0, -32768, -32768, -32768, -32768));
    send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      load_random_triangle(tri_kind_e'(p % 4));
      for (int n = 0; n < PHASE_QUERIES; n++) send_query(rand_query());
      settle();
    end

    $display("sent %0d support queries over %0d triangle settings, %0d results checked",
             queries_sent, triangles_loaded, results_seen);
    $display("stimulus covered half turns, clamping, non-unit quaternions and tied dots");
    if (mismatch_count == 0 && words_in_flight == 0) begin
      $display("triangle_support_point_core_tb: clean");
    end else begin
      $display("triangle_support_point_core_tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/tsp_pkg.sv
hdl/tsp_quat_matrix.sv
hdl/triangle_support_point_core.sv
hdl/tsp_checker.sv
verif/triangle_support_point_core_checker.sv
verif/triangle_support_point_core_tb.sv
